/* rtl/core/hss_pkg.sv */
// shared types and constants of the streaming horspool search block
`default_nettype none
package hss_pkg;

   // longest pattern the window can hold, and text length at which counting stops
   localparam int unsigned      PATTERN_MAX = 16;
   localparam longint unsigned  TEXT_MAX    = 65536;

   // register and field widths
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned REG_W      = 64;
   localparam int unsigned REG_BYTES  = 16;                  // pattern bytes held in registers
   localparam int unsigned PAT_W      = REG_BYTES * 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned OFFSET_W   = 16;
   localparam int unsigned POS_W      = $clog2(TEXT_MAX) + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = 2'd2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_start;
      logic                text_too_long;
   } rsp_payload_type;

endpackage
`default_nettype wire

/* rtl/core/horspool_stream_search.sv */
// top level of the streaming horspool search block
`default_nettype none
// Streaming Boyer-Moore-Horspool search. Text bytes arrive one per transfer on
// the req channel; the last byte of a text carries last_byte. The block keeps the
// newest PATTERN_MAX bytes in a shift window and compares its newest pattern
// length bytes with the pattern only when the arriving byte sits at the current
// check position; on a mismatch it moves on by the bad-character shift of that
// byte. On the byte marked last one transfer on the rsp channel reports found,
// the offset of the first match (zero when not found) and text_too_long, set
// when the text ran past TEXT_MAX bytes; then the search state clears for the
// next text. Throughput is one byte per clock while req_stall is low: a byte is
// registered on acceptance and processed in the following cycle (window compare,
// shift lookup and check-position add in one pass), and a last-marked byte puts
// its result in the result register, but only a last-marked byte can wait on a
// stalled result register, which is what can hold req_stall high. Program the
// pattern through the csr port while no text is in flight; writing pattern_length
// before the first byte of a text also restarts its check position.
module horspool_stream_search
   import hss_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // text byte input
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_payload_type      req_payload,
   // search result output
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_payload_type           rsp_payload,
   // configuration writes
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   // input register
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_payload_ff, s1_payload_in;

   // configuration
   logic [LEN_W-1:0] len_ff, len_in;
   logic [PAT_W-1:0] pattern_ff, pattern_in;

   // search state for the current text
   logic [7:0]          window_ff [PATTERN_MAX];
   logic [7:0]          window_in [PATTERN_MAX];
   logic [POS_W-1:0]    bytes_seen_ff, bytes_seen_in;
   logic [POS_W-1:0]    next_check_ff, next_check_in;
   logic                match_seen_ff, match_seen_in;
   logic [OFFSET_W-1:0] match_offset_ff, match_offset_in;
   logic                overflowed_ff, overflowed_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic             out_free;
   logic             advance;
   logic             req_xfer;
   logic [LEN_W-1:0] eff_len;
   logic [7:0]       win_shift [PATTERN_MAX];
   logic             in_range;
   logic             check_now;
   logic             hit;
   logic [LEN_W-1:0] shift;
   logic [POS_W:0]   check_sum;
   logic [POS_W:0]   pos_plus1;
   logic             new_match;
   logic             new_overflow;
   logic [OFFSET_W-1:0] new_offset;

   // length clamped to 1..PATTERN_MAX
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] r;
      r = len;
      if (len == '0) begin
         r = LEN_W'(1);
      end else if (32'(len) > PATTERN_MAX) begin
         r = LEN_W'(PATTERN_MAX);
      end
      return r;
   endfunction

   // pattern byte at an index, zero beyond the register bytes
   function automatic logic [7:0] pat_at(input logic [PAT_W-1:0] pat,
                                         input logic [LEN_W-1:0] idx);
      logic [7:0] r;
      r = 8'd0;
      if (32'(idx) < REG_BYTES) begin
         r = pat[8*idx +: 8];
      end
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a last-marked byte needs a free result slot, any other byte always proceeds
   assign advance   = s1_valid_ff && (!s1_payload_ff.last_byte || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign eff_len = clamp_len(len_ff);

   // window after the new byte is shifted in, newest at index 0
   always_comb begin
      win_shift[0] = s1_payload_ff.text_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_shift[k] = window_ff[k-1];
      end
   end

   assign in_range  = bytes_seen_ff != POS_W'(TEXT_MAX);
   assign check_now = in_range && !match_seen_ff && (bytes_seen_ff == next_check_ff);

   // compare of the newest pattern-length window bytes, the oldest of them to pattern byte 0
   always_comb begin
      hit = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if ((j < 32'(eff_len)) &&
             (win_shift[j] != pat_at(pattern_ff, eff_len - LEN_W'(j) - LEN_W'(1)))) begin
            hit = 1'b0;
         end
      end
   end

   // bad-character shift: last pattern byte before the final one equal to the new byte
   always_comb begin
      shift = eff_len;
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
         if ((i + 1 < 32'(eff_len)) &&
             (pat_at(pattern_ff, LEN_W'(i)) == s1_payload_ff.text_byte)) begin
            shift = eff_len - LEN_W'(i) - LEN_W'(1);
         end
      end
   end

   assign check_sum = {1'b0, next_check_ff} + (POS_W+1)'(shift);
   assign pos_plus1 = {1'b0, bytes_seen_ff} + (POS_W+1)'(1);

   always_comb begin
      new_match    = match_seen_ff;
      new_offset   = match_offset_ff;
      new_overflow = overflowed_ff || !in_range;
      if (check_now && hit) begin
         new_match = 1'b1;
         if (pos_plus1 >= (POS_W+1)'(eff_len)) begin
            new_offset = OFFSET_W'(pos_plus1 - (POS_W+1)'(eff_len));
         end else begin
            new_offset = '0;
         end
      end
   end

   always_comb begin
      s1_valid_in      = s1_valid_ff;
      s1_payload_in    = s1_payload_ff;
      len_in           = len_ff;
      pattern_in       = pattern_ff;
      window_in        = window_ff;
      bytes_seen_in    = bytes_seen_ff;
      next_check_in    = next_check_ff;
      match_seen_in    = match_seen_ff;
      match_offset_in  = match_offset_ff;
      overflowed_in    = overflowed_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_payload_in   = rsp_payload_ff;

      // input register
      if (req_xfer) begin
         s1_valid_in   = 1'b1;
         s1_payload_in = req_payload;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      // result register drains when taken
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes, only while no text is in flight: a rule for the user, not enforced by the block
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: begin
               len_in = csr_wdata[LEN_W-1:0];
               if (bytes_seen_ff == '0) begin
                  next_check_in = POS_W'(clamp_len(csr_wdata[LEN_W-1:0]) - LEN_W'(1));
               end
            end
            CSR_PATTERN_LOW:  pattern_in[REG_W-1:0]     = csr_wdata;
            CSR_PATTERN_HIGH: pattern_in[PAT_W-1:REG_W] = csr_wdata;
            default: ;
         endcase
      end

      // process the registered byte
      if (advance) begin
         window_in     = win_shift;
         overflowed_in = new_overflow;
         if (in_range) begin
            bytes_seen_in   = POS_W'(pos_plus1);
            match_seen_in   = new_match;
            match_offset_in = new_offset;
            if (check_now && !hit) begin
               if (check_sum > (POS_W+1)'(TEXT_MAX)) begin
                  next_check_in = POS_W'(TEXT_MAX);
               end else begin
                  next_check_in = POS_W'(check_sum);
               end
            end
         end

         if (s1_payload_ff.last_byte) begin
            rsp_valid_in                 = 1'b1;
            rsp_payload_in.found         = new_match;
            rsp_payload_in.match_start   = new_match ? new_offset : '0;
            rsp_payload_in.text_too_long = new_overflow;
            // clear for the next text
            for (int k = 0; k < PATTERN_MAX; k++) begin
               window_in[k] = 8'd0;
            end
            bytes_seen_in   = '0;
            next_check_in   = POS_W'(eff_len - LEN_W'(1));
            match_seen_in   = 1'b0;
            match_offset_in = '0;
            overflowed_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_payload_ff  <= s1_payload_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         len_ff          <= LEN_W'(1);
         pattern_ff      <= '0;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            window_ff[k] <= 8'd0;
         end
         bytes_seen_ff   <= '0;
         next_check_ff   <= '0;
         match_seen_ff   <= 1'b0;
         match_offset_ff <= '0;
         overflowed_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         len_ff          <= len_in;
         pattern_ff      <= pattern_in;
         window_ff       <= window_in;
         bytes_seen_ff   <= bytes_seen_in;
         next_check_ff   <= next_check_in;
         match_seen_ff   <= match_seen_in;
         match_offset_ff <= match_offset_in;
         overflowed_ff   <= overflowed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

/* rtl/core/hss_checker.sv */
// port-level checks for the streaming horspool search block and their bind
`default_nettype none
module hss_checker
   import hss_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire req_payload_type      req_payload,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire rsp_payload_type      rsp_payload,
   input wire logic                 csr_wr_en,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [REG_W-1:0]     csr_wdata
);

   // a stalled result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // no result leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a miss reports a zero offset
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.match_start == '0)
      else $error("nonzero offset without a match");

   // a new result needs a last-marked byte transferred earlier, through the input register
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_payload.last_byte, 2))
      else $error("result without a cause");

   // configuration is written only with no result waiting and known contents
   a_csr_quiet: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> !rsp_valid && !$isunknown({csr_index, csr_wdata}))
      else $error("configuration write while a result waits");

endmodule

bind horspool_stream_search hss_checker u_hss_checker (.*);
`default_nettype wire

/* bench/hss_result_checker.sv */
// scoreboard for the streaming horspool search: predicts each search result and compares it
`timescale 1ns / 100ps
module hss_result_checker
   import hss_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_payload_type      req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_payload_type      rsp_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata,
   output int unsigned               error_count,
   output int unsigned               results_owed
);

   // programmed pattern, low register in bits 63:0
   logic [LEN_W-1:0]    cfg_len;
   logic [PAT_W-1:0]    cfg_pattern;

   // search state of the text in flight, newest byte at window[0]
   logic [7:0]          window [PATTERN_MAX];
   logic [POS_W-1:0]    seen;
   logic [POS_W-1:0]    check_pos;
   logic                hit;
   logic [OFFSET_W-1:0] hit_offset;
   logic                overrun;

   rsp_payload_type     owed_results [$];
   int unsigned         errors;

   // lengths outside 1..PATTERN_MAX are clamped
   function automatic int unsigned active_len();
      if (cfg_len == 0) return 1;
      if (cfg_len > PATTERN_MAX) return PATTERN_MAX;
      return cfg_len;
   endfunction

   task automatic restart_text();
      for (int k = 0; k < PATTERN_MAX; k++) window[k] = 8'h00;
      seen       = '0;
      check_pos  = POS_W'(active_len() - 1);
      hit        = 1'b0;
      hit_offset = '0;
      overrun    = 1'b0;
   endtask

   always @(posedge clock) begin
      int unsigned     m;
      int unsigned     shift;
      int unsigned     next_pos;
      logic            same;
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         cfg_len     = LEN_W'(1);
         cfg_pattern = '0;
         restart_text();
         owed_results.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_LENGTH: begin
                  cfg_len = csr_wdata[LEN_W-1:0];
                  if (seen == 0) check_pos = POS_W'(active_len() - 1);
               end
               CSR_PATTERN_LOW:  cfg_pattern[REG_W-1:0]     = csr_wdata;
               CSR_PATTERN_HIGH: cfg_pattern[PAT_W-1:REG_W] = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            m = active_len();
            for (int k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = req_payload.text_byte;
            if (seen >= TEXT_MAX) begin
               overrun = 1'b1;
            end else begin
               if (!hit && seen == check_pos) begin
                  same = 1'b1;
                  for (int j = 0; j < m; j++)
                     if (window[j] != cfg_pattern[8*(m-1-j) +: 8]) same = 1'b0;
                  if (same) begin
                     hit        = 1'b1;
                     hit_offset = (seen + 1 >= m) ? OFFSET_W'(seen + 1 - m) : '0;
                  end else begin
                     // bad-character shift keyed by the newest byte
                     shift = m;
                     for (int i = 0; i + 1 < m; i++)
                        if (cfg_pattern[8*i +: 8] == window[0]) shift = m - 1 - i;
                     next_pos  = check_pos + shift;
                     check_pos = (next_pos > TEXT_MAX) ? POS_W'(TEXT_MAX) : POS_W'(next_pos);
                  end
               end
               seen = seen + 1'b1;
            end
            if (req_payload.last_byte) begin
               want.found         = hit;
               want.match_start   = hit ? hit_offset : '0;
               want.text_too_long = overrun;
               owed_results.push_back(want);
               restart_text();
            end
         end

         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (owed_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result found=%0d start=%0d too_long=%0d",
                           $realtime, got.found, got.match_start, got.text_too_long);
            end else begin
               want = owed_results.pop_front();
               if (got.found !== want.found || got.match_start !== want.match_start ||
                   got.text_too_long !== want.text_too_long) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: result mismatch, expected found=%0d start=%0d ",
                               "too_long=%0d, got found=%0d start=%0d too_long=%0d"},
                              $realtime, want.found, want.match_start, want.text_too_long,
                              got.found, got.match_start, got.text_too_long);
               end
            end
         end
      end
      error_count  <= errors;
      results_owed <= owed_results.size();
   end

endmodule

/* bench/tb_horspool_stream_search.sv */
// testbench top of the streaming horspool search: drives patterns and texts, gives the verdict
`timescale 1ns / 100ps
module tb_horspool_stream_search;
   import hss_pkg::*;

   typedef logic [7:0] text_buf_t [$];

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_PATTERN_LENGTH;
   logic [REG_W-1:0]     csr_wdata   = '0;

   int unsigned          error_count;
   int unsigned          results_owed;

   // while set, neither side idles
   bit                   calm        = 1'b0;
   // last programmed pattern, kept for building texts that contain it
   logic [LEN_W-1:0]     pat_len     = LEN_W'(1);
   logic [PAT_W-1:0]     pat_bits    = '0;
   int unsigned          bytes_sent  = 0;

   always #4 clock = ~clock;

   // result side stalls at random, except in calm stretches
   always @(posedge clock) rsp_stall <= !calm && ($urandom_range(99) < 28);

   horspool_stream_search u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   hss_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // one byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value, input logic closing);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{text_byte: value, last_byte: closing};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input text_buf_t txt);
      foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
   endtask

   // drop valid, wait for every owed result, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // registers are only written while no text is in flight
   task automatic program_pattern(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] bits);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PATTERN_LOW;
      csr_wdata <= bits[REG_W-1:0];
      @(posedge clock);
      csr_index <= CSR_PATTERN_HIGH;
      csr_wdata <= bits[PAT_W-1:REG_W];
      @(posedge clock);
      csr_index <= CSR_PATTERN_LENGTH;
      csr_wdata <= REG_W'(len);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pat_len  = len;
      pat_bits = bits;
   endtask

   // text past the position limit; filler stays below 0x80 so it never
   // meets a pattern whose bytes all have the top bit set
   task automatic send_long_text(input bit plant);
      int unsigned total;
      int unsigned spot;
      logic [7:0]  value;
      total = TEXT_MAX + 8;
      for (int unsigned k = 0; k < total; k++) begin
         spot = k - (TEXT_MAX - 16);
         if (plant && k >= TEXT_MAX - 16 && k < TEXT_MAX) value = pat_bits[8*spot +: 8];
         else value = 8'($urandom_range(127));
         send_byte(value, k == total - 1);
      end
   endtask

   initial begin
      text_buf_t        txt;
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] bits;
      logic [7:0]       alpha [3];
      int unsigned      m;
      int unsigned      n;
      int unsigned      spot;
      int unsigned      roll;
      int unsigned      phase;
      int unsigned      base;
      int unsigned      texts_done;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: one zero byte
      send_text('{8'h00});
      send_text('{8'hff, 8'h00});           // match after a mismatch, offset one
      send_text('{8'hff});                  // no match

      // full-length pattern with both byte extremes, found after two filler bytes
      drain();
      program_pattern(LEN_W'(16), {64'h0011_2233_c3ff_0080, 64'h7f80_01fe_a55a_00ff});
      txt = '{8'hff, 8'h00};
      for (int k = 0; k < 16; k++) txt.push_back(pat_bits[8*k +: 8]);
      send_text(txt);

      // texts past the position limit, one with a match right at the limit
      // and one without, which drives the check position into saturation
      drain();
      calm = 1'b1;
      program_pattern(LEN_W'(16), {$urandom, $urandom, $urandom, $urandom} |
                                  {16{8'h80}});
      send_long_text(1'b1);
      send_long_text(1'b0);
      drain();
      calm = 1'b0;

      // random phases: a pattern setting, then a few texts built around it
      base       = bytes_sent;
      texts_done = 0;
      phase      = 0;
      while (bytes_sent - base < 850 || texts_done < 45) begin
         case (phase)
            0:       len = LEN_W'(0);     // clamps to one
            1:       len = LEN_W'(31);    // clamps to PATTERN_MAX
            2:       len = LEN_W'(16);
            3:       len = LEN_W'(1);
            default: len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(31))
                                                    : LEN_W'($urandom_range(1, 16));
         endcase
         if (phase == 2) begin
            bits = '1;
         end else if (phase == 3) begin
            bits = '0;
         end else if ($urandom_range(1) == 0) begin
            // few distinct bytes, so shifts see repeated pattern bytes
            foreach (alpha[a]) alpha[a] = 8'($urandom);
            for (int k = 0; k < 16; k++) bits[8*k +: 8] = alpha[$urandom_range(2)];
         end else begin
            bits = {$urandom, $urandom, $urandom, $urandom};
         end
         drain();
         program_pattern(len, bits);
         m = (pat_len == 0) ? 1 : ((pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len);

         repeat ($urandom_range(1, 6)) begin
            n   = ($urandom_range(9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
            txt = {};
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(3) == 0) begin
                  txt.push_back(8'($urandom));
               end else begin
                  spot = $urandom_range(m - 1);
                  txt.push_back(pat_bits[8*spot +: 8]);
               end
            end
            // mostly plant the pattern, sometimes with one bit flipped
            roll = $urandom_range(99);
            if (roll < 55 && n >= m) begin
               spot = $urandom_range(n - m);
               for (int j = 0; j < m; j++) txt[spot + j] = pat_bits[8*j +: 8];
               if (roll < 12) txt[spot + $urandom_range(m - 1)] ^= 8'(1 << $urandom_range(7));
            end
            send_text(txt);
            texts_done++;
         end
         phase++;
      end

      drain();
      if (error_count == 0 && results_owed == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #16_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
